// ===== hw/rtl/ssnf_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number formatter package
// Shared types, register indexes, segment codes and divider sizing for the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ssnf_pkg;

  // Display geometry.
  localparam int unsigned NUM_DIGITS_DEF = 8;
  localparam int unsigned STORE_DEPTH    = 8;
  localparam int unsigned SEG_W          = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_MASK    = 2'd1;

  // Reset values of the registers.
  localparam logic [3:0]       DIGITS_RESET = 4'd8;
  localparam logic [SEG_W-1:0] POINTS_RESET = 8'h02;

  // Special segment patterns (active low).
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h3f;

  // Radix divider: quotient bits retired per cycle and cycles per digit.
  localparam int unsigned DIV_W              = 32;
  localparam int unsigned DIV_BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_CYCLES         = DIV_W / DIV_BITS_PER_CYCLE;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_WRITE_ONE = 2'd0,
    REQ_WRITE_ALL = 2'd1,
    REQ_FORMAT    = 2'd2
  } req_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_PAD,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic put_digit;
    logic put_pad;
    logic put_sign;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fmt;
    logic div_last;
    logic more_digits;
    logic pad_more;
  } status_t;

  // Hex digit to active-low segment pattern.
  function automatic logic [SEG_W-1:0] hex_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'h0: s = 8'hc0;
      4'h1: s = 8'hf9;
      4'h2: s = 8'ha4;
      4'h3: s = 8'hb0;
      4'h4: s = 8'h99;
      4'h5: s = 8'h92;
      4'h6: s = 8'h82;
      4'h7: s = 8'hf8;
      4'h8: s = 8'h80;
      4'h9: s = 8'h90;
      4'ha: s = 8'h88;
      4'hb: s = 8'h83;
      4'hc: s = 8'hc6;
      4'hd: s = 8'ha1;
      4'he: s = 8'h86;
      4'hf: s = 8'h8e;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Pattern shown after reset for each digit.
  function automatic logic [SEG_W-1:0] reset_seg(input logic [2:0] k);
    logic [SEG_W-1:0] s;
    unique case (k)
      3'd1:    s = 8'hf9;
      3'd2:    s = 8'h89;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number formatter controller
// Sequences one request: load, digit division and writes, padding, sign,
// and the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  ssnf_pkg::status_t     status_i,
  output ssnf_pkg::cmd_t        cmd_o,
  output logic                  busy,
  output logic                  result_valid_o
);

  ssnf_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssnf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ssnf_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.is_fmt ? ssnf_pkg::ST_DIV : ssnf_pkg::ST_EMIT;
        end
      end
      ssnf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ssnf_pkg::ST_DIGIT;
        end
      end
      ssnf_pkg::ST_DIGIT: begin
        cmd_o.put_digit = 1'b1;
        state_d = status_i.more_digits ? ssnf_pkg::ST_DIV : ssnf_pkg::ST_PAD;
      end
      ssnf_pkg::ST_PAD: begin
        if (status_i.pad_more) begin
          cmd_o.put_pad = 1'b1;
        end else begin
          state_d = ssnf_pkg::ST_SIGN;
        end
      end
      ssnf_pkg::ST_SIGN: begin
        cmd_o.put_sign = 1'b1;
        state_d        = ssnf_pkg::ST_EMIT;
      end
      ssnf_pkg::ST_EMIT: begin
        state_d = ssnf_pkg::ST_IDLE;
      end
      default: begin
        state_d = ssnf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != ssnf_pkg::ST_IDLE);
  assign result_valid_o = (state_q == ssnf_pkg::ST_EMIT);

endmodule

`default_nettype wire

// ===== hw/rtl/ssnf_dpath.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number formatter datapath
// Pattern store, configuration registers, radix divider and the field
// position counters, driven by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ssnf_dpath #(
  parameter int unsigned NumDigits = ssnf_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration writes.
  input  wire logic                              cfg_we_i,
  input  wire logic [ssnf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ssnf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request fields.
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [63:0]                       pattern_word_i,
  input  wire logic [7:0]                        one_pattern_i,
  input  wire logic [2:0]                        digit_pos_i,
  input  wire logic signed [31:0]                number_i,
  input  wire logic [4:0]                        radix_i,
  input  wire logic [3:0]                        field_len_i,
  input  wire logic [2:0]                        first_pos_i,
  input  wire logic                              zero_pad_i,
  input  wire logic                              show_sign_i,
  // Controller link.
  input  ssnf_pkg::cmd_t                         cmd_i,
  output ssnf_pkg::status_t                      status_o,
  // Packed display.
  output logic [31:0]                            low_word_o,
  output logic [31:0]                            high_word_o
);

  localparam int unsigned DivCntW = $clog2(ssnf_pkg::DIV_CYCLES);
  localparam logic [3:0]  LimitCap = 4'(NumDigits);

  logic [ssnf_pkg::SEG_W-1:0] store_q [ssnf_pkg::STORE_DEPTH];
  logic [3:0]                 digits_q;
  logic [7:0]                 points_q;

  logic [ssnf_pkg::DIV_W-1:0] mag_q;
  logic [3:0]                 rem_q;
  logic [4:0]                 base_q;
  logic [3:0]                 len_q;
  logic [2:0]                 first_q;
  logic [3:0]                 pos_q;
  logic [3:0]                 cnt_q;
  logic                       pad_zero_q;
  logic                       sign_on_q;
  logic [ssnf_pkg::SEG_W-1:0] sign_seg_q;
  logic [DivCntW-1:0]         div_cnt_q;

  logic [3:0]                 limit;
  logic [4:0]                 base_sat;
  logic [3:0]                 len_sat;
  logic                       negate;
  logic [ssnf_pkg::DIV_W-1:0] mag_next;
  logic [3:0]                 rem_next;
  logic [3:0]                 sign_pos;

  logic                       wr_one;
  logic                       wr_all;
  logic [2:0]                 wr_addr;
  logic [ssnf_pkg::SEG_W-1:0] wr_data;

  // Digit limit: digits_in_use, capped at the display width.
  assign limit = (digits_q > LimitCap) ? LimitCap : digits_q;

  // Saturated request fields.
  always_comb begin
    if (radix_i < 5'd2) begin
      base_sat = 5'd2;
    end else if (radix_i > 5'd16) begin
      base_sat = 5'd16;
    end else begin
      base_sat = radix_i;
    end
    if (field_len_i == 4'd0) begin
      len_sat = 4'd1;
    end else if (field_len_i > 4'd8) begin
      len_sat = 4'd8;
    end else begin
      len_sat = field_len_i;
    end
  end

  assign negate = (base_sat == 5'd10) && show_sign_i && number_i[31];

  // Restoring division, several quotient bits per cycle. The remainder
  // stays below the base, so it fits in four bits between steps.
  always_comb begin
    logic [4:0] r5;
    logic       ge;
    mag_next = mag_q;
    rem_next = rem_q;
    for (int b = 0; b < int'(ssnf_pkg::DIV_BITS_PER_CYCLE); b++) begin
      r5       = {rem_next, mag_next[ssnf_pkg::DIV_W-1]};
      ge       = (r5 >= base_q);
      mag_next = {mag_next[ssnf_pkg::DIV_W-2:0], ge};
      rem_next = ge ? 4'(r5 - base_q) : r5[3:0];
    end
  end

  assign sign_pos = 4'({1'b0, first_q} + len_q - 4'd1);

  // Status for the controller.
  always_comb begin
    status_o.is_fmt      = (req_type_i == ssnf_pkg::REQ_FORMAT);
    status_o.div_last    = (div_cnt_q == DivCntW'(ssnf_pkg::DIV_CYCLES - 1));
    status_o.more_digits = (mag_q != '0) && ((cnt_q + 4'd1) < len_q)
                           && ((pos_q + 4'd1) < limit);
    status_o.pad_more    = (cnt_q < len_q) && (pos_q < limit);
  end

  // Store write selection.
  always_comb begin
    wr_one  = 1'b0;
    wr_all  = 1'b0;
    wr_addr = pos_q[2:0];
    wr_data = ssnf_pkg::hex_seg(rem_q);
    if (cmd_i.load) begin
      unique case (req_type_i)
        ssnf_pkg::REQ_WRITE_ONE: begin
          wr_one  = 1'b1;
          wr_addr = digit_pos_i;
          wr_data = one_pattern_i;
        end
        ssnf_pkg::REQ_WRITE_ALL: wr_all = 1'b1;
        default: ;
      endcase
    end else if (cmd_i.put_digit) begin
      wr_one = (pos_q < limit);
    end else if (cmd_i.put_pad) begin
      wr_one  = (pos_q < limit);
      wr_data = pad_zero_q ? ssnf_pkg::hex_seg(4'h0) : ssnf_pkg::SEG_BLANK;
    end else if (cmd_i.put_sign) begin
      wr_one  = sign_on_q && (sign_pos < limit);
      wr_addr = sign_pos[2:0];
      wr_data = sign_seg_q;
    end
  end

  // Pattern store and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(ssnf_pkg::STORE_DEPTH); k++) begin
        store_q[k] <= ssnf_pkg::reset_seg(3'(k));
      end
      digits_q <= ssnf_pkg::DIGITS_RESET;
      points_q <= ssnf_pkg::POINTS_RESET;
    end else begin
      if (wr_all) begin
        for (int k = 0; k < int'(ssnf_pkg::STORE_DEPTH); k++) begin
          store_q[k] <= pattern_word_i[8*k +: 8];
        end
      end else if (wr_one) begin
        store_q[wr_addr] <= wr_data;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ssnf_pkg::CFG_DIGITS_IN_USE: digits_q <= cfg_data_i[3:0];
          ssnf_pkg::CFG_POINT_MASK:    points_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Formatting working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.put_digit) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q      <= negate ? (32'd0 - 32'(number_i)) : 32'(number_i);
      rem_q      <= '0;
      base_q     <= base_sat;
      len_q      <= len_sat;
      first_q    <= first_pos_i;
      pos_q      <= {1'b0, first_pos_i};
      cnt_q      <= '0;
      pad_zero_q <= zero_pad_i;
      sign_on_q  <= show_sign_i;
      sign_seg_q <= negate ? ssnf_pkg::SEG_MINUS : ssnf_pkg::SEG_BLANK;
    end else if (cmd_i.div_step) begin
      mag_q <= mag_next;
      rem_q <= rem_next;
    end else if (cmd_i.put_digit || cmd_i.put_pad) begin
      rem_q <= '0;
      pos_q <= pos_q + 4'd1;
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // Packed display with inverted decimal points in bit 7 of each byte.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      low_word_o[8*k +: 8]  = {~points_q[k],     store_q[k][6:0]};
      high_word_o[8*k +: 8] = {~points_q[k + 4], store_q[k + 4][6:0]};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/seven_segment_number_formatter_top.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number formatter
// Keeps eight active-low digit patterns and formats integers into them.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   req_type selects a single pattern write, an eight-pattern write, or
//   integer formatting in a base from 2 to 16. Every request produces one
//   result: both packed display words, shown for exactly one cycle with
//   result_valid_o high. The receiver cannot stall the result.
//   Pattern writes and unknown requests show the result in the cycle after
//   the transfer. Formatting runs the shared radix divider for each
//   extracted digit, eight quotient bits per divider step, then writes the
//   digit; it then writes each padded position, leaves padding, passes over
//   the sign position and shows the result. busy is high until the result
//   cycle has ended.
//   The configuration channel (cfg_valid_i / cfg_ready_o) is ready while the
//   block is idle; a transfer writes digits_in_use (index 0) or point_mask
//   (index 1).
//   Reset restores the power-up pattern, digits_in_use 8, point_mask 0x02.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_number_formatter_top #(
  parameter int unsigned NumDigits = ssnf_pkg::NUM_DIGITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration channel.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ssnf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ssnf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request channel.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [63:0]                       pattern_word_i,
  input  wire logic [7:0]                        one_pattern_i,
  input  wire logic [2:0]                        digit_pos_i,
  input  wire logic signed [31:0]                number_i,
  input  wire logic [4:0]                        radix_i,
  input  wire logic [3:0]                        field_len_i,
  input  wire logic [2:0]                        first_pos_i,
  input  wire logic                              zero_pad_i,
  input  wire logic                              show_sign_i,
  // Result channel.
  output logic                                   result_valid_o,
  output logic [31:0]                            low_word_o,
  output logic [31:0]                            high_word_o
);

  ssnf_pkg::cmd_t    cmd;
  ssnf_pkg::status_t status;

  // Registers only change while no request is in progress.
  assign cfg_ready_o = !busy;

  // Sequencer.
  ssnf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // Store, registers and divider.
  ssnf_dpath #(
    .NumDigits (NumDigits)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .pattern_word_i (pattern_word_i),
    .one_pattern_i  (one_pattern_i),
    .digit_pos_i    (digit_pos_i),
    .number_i       (number_i),
    .radix_i        (radix_i),
    .field_len_i    (field_len_i),
    .first_pos_i    (first_pos_i),
    .zero_pad_i     (zero_pad_i),
    .show_sign_i    (show_sign_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .low_word_o     (low_word_o),
    .high_word_o    (high_word_o)
  );

  // An accepted request always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  // The result strobe lasts one cycle and ends the request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!result_valid_o && !busy))
    else $error("result strobe not followed by idle");

  // A result is only shown while a request is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a request");

endmodule

`default_nettype wire

// ===== tb/seven_segment_number_formatter_top_tb.sv =====
// ----------------------------------------------------------------------------
// Seven-segment number formatter testbench
// Drives pattern writes, bulk writes, integer formatting and unknown requests
// through the start/busy port. A shadow copy of the digit store and of the
// two registers predicts both packed display words for every transfer, and
// each result strobe is checked in order against those predictions.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block must ignore apart from showing the display.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Active-low glyphs for hex digits 0..f.
  localparam logic [7:0] HEX_GLYPH [16] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
    8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e
  };

  // Cycles without any transfer or result before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct {
    logic [1:0]         kind;
    logic [63:0]        patterns;
    logic [7:0]         glyph;
    logic [2:0]         glyph_pos;
    logic signed [31:0] number;
    logic [4:0]         radix;
    logic [3:0]         field_len;
    logic [2:0]         first_pos;
    logic               zero_pad;
    logic               show_sign;
  } disp_req_t;

  typedef struct {
    logic [31:0] low;
    logic [31:0] high;
  } disp_words_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [ssnf_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ssnf_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [63:0] pattern_word_i = '0;
  logic [7:0]  one_pattern_i = '0;
  logic [2:0]  digit_pos_i = '0;
  logic signed [31:0] number_i = '0;
  logic [4:0]  radix_i = 5'd10;
  logic [3:0]  field_len_i = 4'd1;
  logic [2:0]  first_pos_i = '0;
  logic        zero_pad_i = 1'b0;
  logic        show_sign_i = 1'b0;
  logic        result_valid_o;
  logic [31:0] low_word_o;
  logic [31:0] high_word_o;

  // Shadow state of the display.
  logic [7:0]  shadow_seg [8];
  logic [3:0]  shadow_digits;
  logic [7:0]  shadow_points;

  disp_words_t expected_words_q [$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned kind_count [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;
  bit          steady_feed = 1'b0;

  seven_segment_number_formatter_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .pattern_word_i (pattern_word_i),
    .one_pattern_i  (one_pattern_i),
    .digit_pos_i    (digit_pos_i),
    .number_i       (number_i),
    .radix_i        (radix_i),
    .field_len_i    (field_len_i),
    .first_pos_i    (first_pos_i),
    .zero_pad_i     (zero_pad_i),
    .show_sign_i    (show_sign_i),
    .result_valid_o (result_valid_o),
    .low_word_o     (low_word_o),
    .high_word_o    (high_word_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Digit glyphs shown right after reset.
  function automatic logic [7:0] reset_glyph(int k);
    if (k == 1) return 8'hf9;
    else if (k == 2) return 8'h89;
    else return ssnf_pkg::SEG_BLANK;
  endfunction

  // Writes a glyph unless the position lies at or above the digit limit.
  function automatic void place_glyph(int unsigned pos, int unsigned lim, logic [7:0] g);
    if (pos < lim && pos < 8) begin
      shadow_seg[pos] = g;
    end
  endfunction

  // Formats a number into the shadow store, digits least significant first.
  function automatic void format_into_shadow(disp_req_t r);
    int unsigned base;
    int unsigned len;
    int unsigned lim;
    int unsigned cnt;
    int unsigned pos;
    logic [31:0] mag;
    logic [7:0]  sign_glyph;
    base = r.radix;
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    len = r.field_len;
    if (len < 1) len = 1;
    if (len > 8) len = 8;
    lim = (shadow_digits > 8) ? 8 : shadow_digits;
    mag = r.number;
    sign_glyph = ssnf_pkg::SEG_BLANK;
    // A minus bar only exists for negative numbers in decimal.
    if (base == 10 && r.show_sign && r.number[31]) begin
      mag = -r.number;
      sign_glyph = ssnf_pkg::SEG_MINUS;
    end
    cnt = 0;
    pos = r.first_pos;
    do begin
      place_glyph(pos, lim, HEX_GLYPH[mag % base]);
      mag = mag / base;
      cnt++;
      pos++;
    end while (mag > 0 && cnt < len && pos < lim);
    // Leading positions of the field.
    while (cnt < len && pos < lim) begin
      place_glyph(pos, lim, r.zero_pad ? HEX_GLYPH[0] : ssnf_pkg::SEG_BLANK);
      cnt++;
      pos++;
    end
    if (r.show_sign) begin
      place_glyph(r.first_pos + len - 1, lim, sign_glyph);
    end
  endfunction

  // Applies one request to the shadow store and queues the display words.
  function automatic void predict_display(disp_req_t r);
    disp_words_t w;
    logic [7:0]  b;
    case (r.kind)
      ssnf_pkg::REQ_WRITE_ONE: shadow_seg[r.glyph_pos] = r.glyph;
      ssnf_pkg::REQ_WRITE_ALL: begin
        for (int k = 0; k < 8; k++) shadow_seg[k] = r.patterns[8*k +: 8];
      end
      ssnf_pkg::REQ_FORMAT: format_into_shadow(r);
      default: ;
    endcase
    // Bit 7 of every byte carries the inverted point mask.
    for (int k = 0; k < 8; k++) begin
      b = {~shadow_points[k], shadow_seg[k][6:0]};
      if (k < 4) w.low[8*k +: 8] = b;
      else w.high[8*(k-4) +: 8] = b;
    end
    expected_words_q.push_back(w);
  endfunction

  // Checks each result against the oldest prediction.
  always @(posedge clk_i) begin
    disp_words_t w;
    if (rst_ni && result_valid_o) begin
      results_seen <= results_seen + 1;
      if (expected_words_q.size() == 0) begin
        $error("unexpected result: low_word %08h, high_word %08h", low_word_o, high_word_o);
        mismatch_count++;
      end else begin
        w = expected_words_q.pop_front();
        if (low_word_o !== w.low) begin
          $error("low_word: expected %08h, got %08h", w.low, low_word_o);
          mismatch_count++;
        end
        if (high_word_o !== w.high) begin
          $error("high_word: expected %08h, got %08h", w.high, high_word_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer of any kind.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request, after a random gap unless steady_feed is set, and predicts it once busy is low.
  task automatic send_request(disp_req_t r);
    while (!steady_feed && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= r.kind;
    pattern_word_i <= r.patterns;
    one_pattern_i  <= r.glyph;
    digit_pos_i    <= r.glyph_pos;
    number_i       <= r.number;
    radix_i        <= r.radix;
    field_len_i    <= r.field_len;
    first_pos_i    <= r.first_pos;
    zero_pad_i     <= r.zero_pad;
    show_sign_i    <= r.show_sign;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_display(r);
    kind_count[r.kind]++;
  endtask

  // Lets the block drain every pending result before a register write.
  task automatic settle_display();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_words_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ssnf_pkg::CFG_IDX_W-1:0] idx,
                           logic [ssnf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == ssnf_pkg::CFG_DIGITS_IN_USE) shadow_digits = data[3:0];
    else if (idx == ssnf_pkg::CFG_POINT_MASK) shadow_points = data;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random filler so that unused fields still toggle.
  function automatic disp_req_t noise_req(logic [1:0] kind);
    disp_req_t r;
    r.kind      = kind;
    r.patterns  = {$urandom, $urandom};
    r.glyph     = 8'($urandom_range(255));
    r.glyph_pos = 3'($urandom_range(7));
    r.number    = $urandom;
    r.radix     = 5'($urandom_range(31));
    r.field_len = 4'($urandom_range(15));
    r.first_pos = 3'($urandom_range(7));
    r.zero_pad  = 1'($urandom_range(1));
    r.show_sign = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic disp_req_t one_req(logic [2:0] pos, logic [7:0] g);
    disp_req_t r;
    r = noise_req(ssnf_pkg::REQ_WRITE_ONE);
    r.glyph_pos = pos;
    r.glyph = g;
    return r;
  endfunction

  function automatic disp_req_t all_req(logic [63:0] word);
    disp_req_t r;
    r = noise_req(ssnf_pkg::REQ_WRITE_ALL);
    r.patterns = word;
    return r;
  endfunction

  function automatic disp_req_t fmt_req(logic signed [31:0] num, logic [4:0] radix,
                                        logic [3:0] len, logic [2:0] first,
                                        logic pad, logic sign);
    disp_req_t r;
    r = noise_req(ssnf_pkg::REQ_FORMAT);
    r.number    = num;
    r.radix     = radix;
    r.field_len = len;
    r.first_pos = first;
    r.zero_pad  = pad;
    r.show_sign = sign;
    return r;
  endfunction

  // Random request, mostly formatting with display-sized fields.
  function automatic disp_req_t random_req();
    disp_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) r = noise_req(ssnf_pkg::REQ_WRITE_ONE);
    else if (pick < 35) r = noise_req(ssnf_pkg::REQ_WRITE_ALL);
    else if (pick < 95) r = noise_req(ssnf_pkg::REQ_FORMAT);
    else r = noise_req(REQ_UNKNOWN);
    case ($urandom_range(3))
      0: r.number = $urandom_range(999);
      1: r.number = -$signed($urandom_range(1000));
      2: r.number = $urandom;
      default: begin
        case ($urandom_range(3))
          0: r.number = 32'sh8000_0000;
          1: r.number = 32'sh7fff_ffff;
          2: r.number = -1;
          default: r.number = 0;
        endcase
      end
    endcase
    pick = $urandom_range(9);
    if (pick < 4) r.radix = 5'd10;
    else if (pick < 8) r.radix = 5'($urandom_range(16, 2));
    if ($urandom_range(99) < 85) r.field_len = 4'($urandom_range(8, 1));
    return r;
  endfunction

  // Power-up display, shown through a request the block does not know.
  task automatic test_power_up();
    send_request(noise_req(REQ_UNKNOWN));
    send_request(one_req(3'd0, 8'h00));
    send_request(one_req(3'd7, 8'hff));
  endtask

  task automatic test_bulk_writes();
    send_request(all_req(64'h0));
    send_request(all_req(64'hffff_ffff_ffff_ffff));
    send_request(all_req(64'h0123_4567_89ab_cdef));
  endtask

  // Sign handling, base and length saturation, padding, field overflow.
  task automatic test_format_cases();
    send_request(fmt_req(32'sh7fff_ffff, 5'd10, 4'd8, 3'd0, 1'b0, 1'b1));
    send_request(fmt_req(32'sh8000_0000, 5'd10, 4'd8, 3'd0, 1'b1, 1'b1));
    send_request(fmt_req(-1, 5'd2, 4'd8, 3'd0, 1'b0, 1'b0));
    send_request(fmt_req(-1, 5'd16, 4'd8, 3'd0, 1'b0, 1'b0));
    send_request(fmt_req(0, 5'd10, 4'd4, 3'd2, 1'b1, 1'b0));
    send_request(fmt_req(5, 5'd10, 4'd4, 3'd2, 1'b0, 1'b1));
    send_request(fmt_req(-42, 5'd16, 4'd6, 3'd0, 1'b0, 1'b1));
    send_request(fmt_req(255, 5'd0, 4'd8, 3'd0, 1'b0, 1'b0));
    send_request(fmt_req(255, 5'd31, 4'd3, 3'd0, 1'b1, 1'b0));
    send_request(fmt_req(7, 5'd10, 4'd0, 3'd3, 1'b1, 1'b0));
    send_request(fmt_req(123, 5'd10, 4'd15, 3'd0, 1'b1, 1'b1));
    send_request(fmt_req(-9, 5'd10, 4'd3, 3'd7, 1'b1, 1'b1));
  endtask

  // Digit limit at zero, one and above the display size; point mask extremes.
  task automatic test_digit_limit();
    settle_display();
    write_reg(ssnf_pkg::CFG_DIGITS_IN_USE, 8'd0);
    write_reg(ssnf_pkg::CFG_POINT_MASK, 8'hff);
    send_request(fmt_req(99, 5'd10, 4'd2, 3'd0, 1'b1, 1'b1));
    settle_display();
    write_reg(ssnf_pkg::CFG_DIGITS_IN_USE, 8'd1);
    write_reg(ssnf_pkg::CFG_POINT_MASK, 8'h00);
    send_request(one_req(3'd7, 8'h00));
    send_request(fmt_req(-4321, 5'd10, 4'd8, 3'd0, 1'b1, 1'b1));
    settle_display();
    write_reg(ssnf_pkg::CFG_DIGITS_IN_USE, 8'd15);
    send_request(fmt_req(-12345678, 5'd16, 4'd8, 3'd0, 1'b0, 1'b0));
  endtask

  // Random requests across several register settings.
  task automatic test_random(int unsigned total);
    int unsigned digit_plan [8] = '{8, 1, 5, 0, 8, 3, 15, 8};
    logic [7:0]  mask;
    for (int phase = 0; phase < 8; phase++) begin
      settle_display();
      if (phase == 0) mask = 8'h00;
      else if (phase == 1) mask = 8'hff;
      else mask = 8'($urandom_range(255));
      write_reg(ssnf_pkg::CFG_DIGITS_IN_USE, 8'(digit_plan[phase]));
      write_reg(ssnf_pkg::CFG_POINT_MASK, mask);
      // One phase runs back to back with no gaps at all.
      steady_feed = (phase == 4);
      for (int n = 0; n < total / 8; n++) send_request(random_req());
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < 8; k++) shadow_seg[k] = reset_glyph(k);
    shadow_digits = 4'd8;
    shadow_points = 8'h02;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_up();
    test_bulk_writes();
    test_format_cases();
    test_digit_limit();
    test_random(2000);

    start <= 1'b0;
    @(posedge clk_i);
    while (expected_words_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d single writes, %0d bulk writes, %0d formats, %0d unknown requests",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("checked %0d results over %0d register writes", results_seen, cfg_writes);
    if (mismatch_count == 0 && expected_words_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
